// ===== src/irpd_pkg.sv =====
`timescale 1ns / 1ps
// irpd_pkg: types, register codes and microcode program for the ir pulse distance encoder
// no dependencies; imported by the encoder top level and its checker

package irpd_pkg;

  localparam int DUR_W      = 16;
  localparam int SUM_W      = 23;
  localparam int CNT_W      = 6;
  localparam int CMD_W      = 32;
  localparam int PREFIX_W   = 16;
  localparam int PCNT_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;
  localparam int STEP_W     = 3;

  typedef logic [STEP_W-1:0] step_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_PULSE = 3'd0,
    REG_HEADER_SPACE = 3'd1,
    REG_ONE_PULSE    = 3'd2,
    REG_ONE_SPACE    = 3'd3,
    REG_ZERO_PULSE   = 3'd4,
    REG_ZERO_SPACE   = 3'd5,
    REG_PREFIX_BITS  = 3'd6,
    REG_PREFIX_COUNT = 3'd7
  } cfg_reg_t;

  // what a step puts on the output
  typedef enum logic [1:0] {
    EM_NONE    = 2'd0,
    EM_HEADER  = 2'd1,
    EM_BIT     = 2'd2,
    EM_TRAILER = 2'd3
  } emit_sel_t;

  typedef enum logic {
    SRC_PREFIX = 1'b0,
    SRC_CMD    = 1'b1
  } src_sel_t;

  // bit counter load when a step is left
  typedef enum logic [1:0] {
    LD_KEEP   = 2'd0,
    LD_PREFIX = 2'd1,
    LD_CMD    = 2'd2
  } load_sel_t;

  // how a step advances
  typedef enum logic [1:0] {
    CD_ALWAYS = 2'd0,
    CD_INPUT  = 2'd1,
    CD_LOOP   = 2'd2
  } cond_t;

  typedef struct packed {
    emit_sel_t emit;
    src_sel_t  src;
    load_sel_t load;
    cond_t     cond;
    step_t     next;
    step_t     alt;
  } ctrl_word_t;

  localparam step_t ST_IDLE    = 3'd0;
  localparam step_t ST_HEADER  = 3'd1;
  localparam step_t ST_PREFIX  = 3'd2;
  localparam step_t ST_COMMAND = 3'd3;
  localparam step_t ST_TRAILER = 3'd4;

  // microcode rom; alt is the jump taken from idle for a headless repeat
  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t cw;
    unique case (step)
      ST_IDLE:    cw = '{EM_NONE,    SRC_PREFIX, LD_PREFIX, CD_INPUT,  ST_HEADER,  ST_PREFIX};
      ST_HEADER:  cw = '{EM_HEADER,  SRC_PREFIX, LD_KEEP,   CD_ALWAYS, ST_PREFIX,  ST_IDLE};
      ST_PREFIX:  cw = '{EM_BIT,     SRC_PREFIX, LD_CMD,    CD_LOOP,   ST_COMMAND, ST_IDLE};
      ST_COMMAND: cw = '{EM_BIT,     SRC_CMD,    LD_KEEP,   CD_LOOP,   ST_TRAILER, ST_IDLE};
      ST_TRAILER: cw = '{EM_TRAILER, SRC_PREFIX, LD_KEEP,   CD_ALWAYS, ST_IDLE,    ST_IDLE};
      default:    cw = '{EM_NONE,    SRC_PREFIX, LD_KEEP,   CD_ALWAYS, ST_IDLE,    ST_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// ===== src/ir_pulse_distance_frame_encoder.sv =====
`timescale 1ns / 1ps
// ir_pulse_distance_frame_encoder: turns one command beat into a frame of mark/space beats
// depends on irpd_pkg (types, register codes, microcode rom)
//
// first result beat: a standard frame goes from the idle step to the header step, a headless
//   repeat to the prefix step; each emitting step registers its beat on the output, and an
//   empty bit loop is left in a step of its own without a beat
// frame: the idle step gives no beat; the header, each loop bit and the trailer give one beat
//   each; leaving each of the two bit loops gives none, and a beat waits while the output
//   register is full; the microcode step counter runs one frame at a time
// reset (rst, synchronous): step counter to idle, output empty, registers to defaults
// the output register is reloaded as the sink takes its beat; an emitting step stalls while a beat waits

module ir_pulse_distance_frame_encoder #(
  parameter int MAX_PREFIX_BITS  = 16,
  parameter int MAX_COMMAND_BITS = 32,
  parameter int TRAILER_PULSE_US = 526
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irpd_pkg::DUR_W-1:0]        cfg_data,
  // command stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [irpd_pkg::IN_DATA_W-1:0]    s_tdata,  // command_bits[31:0], command_count[37:32]
  input  logic                              s_tuser,  // kind
  // mark/space stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [irpd_pkg::OUT_DATA_W-1:0]   m_tdata,  // mark_us[15:0], gap_us[31:16],
                                                      // frame_duration_us[54:32]
  output logic                              m_tuser,  // mark_only
  output logic                              m_tlast   // last
);

  import irpd_pkg::*;

  // configuration registers
  logic [DUR_W-1:0]    header_pulse_us;
  logic [DUR_W-1:0]    header_space_us;
  logic [DUR_W-1:0]    one_pulse_us;
  logic [DUR_W-1:0]    one_space_us;
  logic [DUR_W-1:0]    zero_pulse_us;
  logic [DUR_W-1:0]    zero_space_us;
  logic [PREFIX_W-1:0] prefix_bits;
  logic [PCNT_W-1:0]   prefix_count;

  // sequencer state
  step_t               step;
  logic [CNT_W-1:0]    bit_index;
  logic [CMD_W-1:0]    held_command;
  logic [CNT_W-1:0]    held_count;
  logic [SUM_W-1:0]    duration_sum;

  // output register
  logic [DUR_W-1:0]    mark_us;
  logic [DUR_W-1:0]    gap_us;
  logic [SUM_W-1:0]    frame_duration_us;

  // datapath
  ctrl_word_t          cw;
  logic                slot_free;
  logic [CMD_W-1:0]    bit_word;
  logic [CNT_W-1:0]    index_m1;
  logic                bit_val;
  logic [DUR_W-1:0]    bit_mark;
  logic [DUR_W-1:0]    bit_gap;
  logic [DUR_W-1:0]    hdr_mark;
  logic [DUR_W-1:0]    hdr_gap;
  logic [DUR_W:0]      pair_sum;
  logic [CNT_W-1:0]    prefix_sat;
  logic [CNT_W-1:0]    in_count;
  logic [CNT_W-1:0]    in_count_sat;
  logic [CNT_W-1:0]    load_value;

  assign cw        = ucode(step);
  assign cfg_ready = 1'b1;
  assign s_tready  = (cw.cond == CD_INPUT);
  assign slot_free = !m_tvalid || m_tready;

  assign m_tdata = {1'b0, frame_duration_us, gap_us, mark_us};

  // saturate the counts to the configured maxima
  assign prefix_sat   = ({1'b0, prefix_count} > CNT_W'(MAX_PREFIX_BITS)) ?
                        CNT_W'(MAX_PREFIX_BITS) : {1'b0, prefix_count};
  assign in_count     = s_tdata[CMD_W +: CNT_W];
  assign in_count_sat = (in_count > CNT_W'(MAX_COMMAND_BITS)) ?
                        CNT_W'(MAX_COMMAND_BITS) : in_count;

  // bits go out from the highest element down to bit 0; prefix bits above bit 15 are zero
  assign bit_word = (cw.src == SRC_CMD) ? held_command
                                        : {{(CMD_W-PREFIX_W){1'b0}}, prefix_bits};
  assign index_m1 = bit_index - 1'b1;
  assign bit_val  = bit_word[index_m1[CNT_W-2:0]];
  assign bit_mark = bit_val ? one_pulse_us : zero_pulse_us;
  assign bit_gap  = bit_val ? one_space_us : zero_space_us;
  assign hdr_mark = header_pulse_us;
  assign hdr_gap  = header_space_us;

  always_comb begin
    if (cw.emit == EM_HEADER) begin
      pair_sum = {1'b0, hdr_mark} + {1'b0, hdr_gap};
    end else begin
      pair_sum = {1'b0, bit_mark} + {1'b0, bit_gap};
    end
  end

  always_comb begin
    unique case (cw.load)
      LD_PREFIX: load_value = prefix_sat;
      LD_CMD:    load_value = held_count;
      default:   load_value = bit_index;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_pulse_us <= 16'd8400;
      header_space_us <= 16'd4200;
      one_pulse_us    <= 16'd526;
      one_space_us    <= 16'd1578;
      zero_pulse_us   <= 16'd526;
      zero_space_us   <= 16'd526;
      prefix_bits     <= '0;
      prefix_count    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEADER_PULSE: header_pulse_us <= cfg_data;
        REG_HEADER_SPACE: header_space_us <= cfg_data;
        REG_ONE_PULSE:    one_pulse_us    <= cfg_data;
        REG_ONE_SPACE:    one_space_us    <= cfg_data;
        REG_ZERO_PULSE:   zero_pulse_us   <= cfg_data;
        REG_ZERO_SPACE:   zero_space_us   <= cfg_data;
        REG_PREFIX_BITS:  prefix_bits     <= cfg_data;
        REG_PREFIX_COUNT: prefix_count    <= cfg_data[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // microcode sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= ST_IDLE;
      bit_index    <= '0;
      held_command <= '0;
      held_count   <= '0;
      duration_sum <= '0;
      m_tvalid     <= 1'b0;
      m_tuser      <= 1'b0;
      m_tlast      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (cw.cond)
        CD_INPUT: begin
          // wait for a command; a headless repeat skips the header step
          if (s_tvalid) begin
            held_command <= s_tdata[CMD_W-1:0];
            held_count   <= in_count_sat;
            duration_sum <= '0;
            bit_index    <= load_value;
            step         <= s_tuser ? cw.alt : cw.next;
          end
        end
        CD_LOOP: begin
          if (bit_index == '0) begin
            step      <= cw.next;
            bit_index <= load_value;
          end else if (slot_free) begin
            m_tvalid          <= 1'b1;
            mark_us           <= bit_mark;
            gap_us            <= bit_gap;
            frame_duration_us <= '0;
            m_tuser           <= 1'b0;
            m_tlast           <= 1'b0;
            bit_index         <= index_m1;
            duration_sum      <= duration_sum + SUM_W'(pair_sum);
          end
        end
        default: begin
          if (slot_free) begin
            step      <= cw.next;
            bit_index <= load_value;
            unique case (cw.emit)
              EM_HEADER: begin
                m_tvalid          <= 1'b1;
                mark_us           <= hdr_mark;
                gap_us            <= hdr_gap;
                frame_duration_us <= '0;
                m_tuser           <= 1'b0;
                m_tlast           <= 1'b0;
                duration_sum      <= duration_sum + SUM_W'(pair_sum);
              end
              EM_TRAILER: begin
                // single mark closes the frame and carries the total
                m_tvalid          <= 1'b1;
                mark_us           <= DUR_W'(TRAILER_PULSE_US);
                gap_us            <= '0;
                frame_duration_us <= duration_sum + SUM_W'(TRAILER_PULSE_US);
                m_tuser           <= 1'b1;
                m_tlast           <= 1'b1;
              end
              default: ;
            endcase
          end
        end
      endcase
    end
  end

endmodule

// ===== src/irpd_checker.sv =====
`timescale 1ns / 1ps
// irpd_checker: port-level assertions for the ir pulse distance encoder, and its bind
// depends on irpd_pkg and ir_pulse_distance_frame_encoder

module irpd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [irpd_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tuser,
  input logic                            m_tlast
);

  import irpd_pkg::*;

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // only the trailer closes a frame
  a_trailer_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == m_tlast))
    else $error("mark_only and last disagree");

  // trailer has no space; other beats carry no total
  a_trailer_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[2*DUR_W-1:DUR_W] == '0))
    else $error("trailer beat with a space");

  a_total_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> (m_tdata[2*DUR_W +: SUM_W] == '0))
    else $error("frame total on a beat that is not last");

  // a frame is in progress after a command is taken
  a_one_command: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command taken while a frame is running");

endmodule

bind ir_pulse_distance_frame_encoder irpd_checker u_irpd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== sim/ir_pulse_distance_frame_encoder_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for ir_pulse_distance_frame_encoder: random and directed commands,
// frames predicted in step with the config writes, and random gaps and stalls on both streams
// depends on irpd_pkg and src/ir_pulse_distance_frame_encoder.sv

module ir_pulse_distance_frame_encoder_test;
  import irpd_pkg::*;

  localparam int TRAILER_US    = 526;
  localparam int MAX_PREFIX    = 16;
  localparam int MAX_CMD       = 32;
  localparam int STALL_LIMIT   = 5000;  // cycles with no beat moving anywhere
  localparam int SETTLE_CYCLES = 8;     // margin for the sequencer to fall back to idle
  localparam int DRAIN_EVERY   = 37;    // sender waits for the frames to empty this often

  // frame kinds carried on s_tuser
  localparam logic KIND_STANDARD = 1'b0;
  localparam logic KIND_REPEAT   = 1'b1;

  typedef struct {
    logic             kind;
    logic [CMD_W-1:0] bits;
    logic [CNT_W-1:0] count;
  } ir_cmd_t;

  typedef struct {
    logic [DUR_W-1:0] mark;
    logic [DUR_W-1:0] gap;
    logic             mark_only;
    logic             last;
    logic [SUM_W-1:0] total;
  } pulse_pair_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [DUR_W-1:0]      cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;  // command_bits[31:0], command_count[37:32]
  logic                  s_tuser   = 1'b0;  // kind
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;  // mark_us[15:0], gap_us[31:16], frame_duration_us[54:32]
  logic                  m_tuser;  // mark_only
  logic                  m_tlast;  // last

  // shadow copy of the timing registers, reset values
  logic [DUR_W-1:0]    hdr_mark    = 16'd8400;
  logic [DUR_W-1:0]    hdr_space   = 16'd4200;
  logic [DUR_W-1:0]    one_mark    = 16'd526;
  logic [DUR_W-1:0]    one_space   = 16'd1578;
  logic [DUR_W-1:0]    zero_mark   = 16'd526;
  logic [DUR_W-1:0]    zero_space  = 16'd526;
  logic [PREFIX_W-1:0] prefix_word = '0;
  logic [PCNT_W-1:0]   prefix_len  = '0;

  ir_cmd_t     cmd_backlog[$];   // commands still to be offered
  pulse_pair_t pairs_due[$];     // predicted mark/space beats, oldest first
  ir_cmd_t     cmd_on_bus;
  logic        cmd_loaded  = 1'b0;
  logic        drain_hold  = 1'b0;
  int          cmds_taken  = 0;
  int          send_idle   = 0;  // percent of cycles the sender holds back
  int          sink_stall  = 0;  // percent of cycles the receiver stalls
  int          mismatches  = 0;
  int          quiet_count = 0;

  ir_pulse_distance_frame_encoder #(
    .MAX_PREFIX_BITS (MAX_PREFIX),
    .MAX_COMMAND_BITS(MAX_CMD),
    .TRAILER_PULSE_US(TRAILER_US)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // one mark/space beat of the frame, running sum kept by the caller
  function automatic void add_pair(input logic [DUR_W-1:0] mark, input logic [DUR_W-1:0] gap);
    pulse_pair_t p;
    p.mark      = mark;
    p.gap       = gap;
    p.mark_only = 1'b0;
    p.last      = 1'b0;
    p.total     = '0;
    pairs_due.push_back(p);
  endfunction

  // whole frame for one command under the current register set
  function automatic void expand_frame(input ir_cmd_t c);
    logic [SUM_W-1:0] sum;
    logic [DUR_W-1:0] mk;
    logic [DUR_W-1:0] sp;
    pulse_pair_t      tail;
    int               n_prefix;
    int               n_cmd;
    int               i;
    sum      = '0;
    n_prefix = (prefix_len > MAX_PREFIX) ? MAX_PREFIX : prefix_len;
    n_cmd    = (c.count > MAX_CMD) ? MAX_CMD : c.count;
    if (c.kind == KIND_STANDARD) begin
      add_pair(hdr_mark, hdr_space);
      sum = sum + hdr_mark + hdr_space;
    end
    // both sequences go out from the highest element down to bit 0
    for (i = n_prefix - 1; i >= 0; i--) begin
      mk  = prefix_word[i] ? one_mark : zero_mark;
      sp  = prefix_word[i] ? one_space : zero_space;
      add_pair(mk, sp);
      sum = sum + mk + sp;
    end
    for (i = n_cmd - 1; i >= 0; i--) begin
      mk  = c.bits[i] ? one_mark : zero_mark;
      sp  = c.bits[i] ? one_space : zero_space;
      add_pair(mk, sp);
      sum = sum + mk + sp;
    end
    tail.mark      = DUR_W'(TRAILER_US);
    tail.gap       = '0;
    tail.mark_only = 1'b1;
    tail.last      = 1'b1;
    tail.total     = sum + SUM_W'(TRAILER_US);
    pairs_due.push_back(tail);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic ir_cmd_t random_cmd();
    ir_cmd_t c;
    int      pick;
    pick    = $urandom_range(9);
    c.kind  = 1'($urandom_range(1));
    c.bits  = $urandom;
    // mostly legal lengths, some over the limit to hit the saturation
    if (pick == 0)
      c.count = CNT_W'($urandom_range(63, MAX_CMD + 1));
    else if (pick == 1)
      c.count = CNT_W'(MAX_CMD);
    else
      c.count = CNT_W'($urandom_range(MAX_CMD - 1));
    return c;
  endfunction

  task automatic queue_cmd(input logic kind, input logic [CMD_W-1:0] bits,
                           input logic [CNT_W-1:0] count);
    ir_cmd_t c;
    c.kind  = kind;
    c.bits  = bits;
    c.count = count;
    cmd_backlog.push_back(c);
  endtask

  // caller sits on a rising edge; cfg_valid stays high across back-to-back writes
  task automatic write_reg(input cfg_reg_t idx, input logic [DUR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_HEADER_PULSE: hdr_mark    = val;
      REG_HEADER_SPACE: hdr_space   = val;
      REG_ONE_PULSE:    one_mark    = val;
      REG_ONE_SPACE:    one_space   = val;
      REG_ZERO_PULSE:   zero_mark   = val;
      REG_ZERO_SPACE:   zero_space  = val;
      REG_PREFIX_BITS:  prefix_word = val;
      REG_PREFIX_COUNT: prefix_len  = val[PCNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_timing(input logic [DUR_W-1:0] hm, input logic [DUR_W-1:0] hs,
                              input logic [DUR_W-1:0] om, input logic [DUR_W-1:0] os,
                              input logic [DUR_W-1:0] zm, input logic [DUR_W-1:0] zs,
                              input logic [DUR_W-1:0] pw, input logic [DUR_W-1:0] pc);
    write_reg(REG_HEADER_PULSE, hm);
    write_reg(REG_HEADER_SPACE, hs);
    write_reg(REG_ONE_PULSE, om);
    write_reg(REG_ONE_SPACE, os);
    write_reg(REG_ZERO_PULSE, zm);
    write_reg(REG_ZERO_SPACE, zs);
    write_reg(REG_PREFIX_BITS, pw);
    write_reg(REG_PREFIX_COUNT, pc);
    cfg_valid <= 1'b0;
  endtask

  // wait until every command is taken and every frame has come out, then let the block settle
  task automatic drain();
    while (cmd_backlog.size() != 0 || cmd_loaded || pairs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pressure(input int idle_pct, input int stall_pct);
    send_idle  <= idle_pct;
    sink_stall <= stall_pct;
  endtask

  // command driver: one beat in flight, predicted at the handshake
  always @(posedge clk) begin : cmd_driver
    if (rst) begin
      s_tvalid   <= 1'b0;
      cmd_loaded = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expand_frame(cmd_on_bus);
        cmd_loaded = 1'b0;
        cmds_taken++;
        if (cmds_taken % DRAIN_EVERY == 0)
          drain_hold = 1'b1;
      end
      // hold off until every predicted beat has been seen
      if (drain_hold && pairs_due.size() == 0)
        drain_hold = 1'b0;
      if (!cmd_loaded && !drain_hold && cmd_backlog.size() != 0 &&
          $urandom_range(99) >= send_idle) begin
        cmd_on_bus = cmd_backlog.pop_front();
        cmd_loaded = 1'b1;
      end
      s_tvalid <= cmd_loaded;
      s_tuser  <= cmd_on_bus.kind;
      s_tdata  <= {{(IN_DATA_W - CMD_W - CNT_W){1'b0}}, cmd_on_bus.count, cmd_on_bus.bits};
    end
  end

  // result monitor: every beat against the oldest prediction, then the next ready
  always @(posedge clk) begin : pair_monitor
    pulse_pair_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pairs_due.size() == 0) begin
          mismatches++;
          $display("%0t: beat with nothing expected, expected none, actual mark %0d gap %0d",
                   $time, m_tdata[15:0], m_tdata[31:16]);
        end else begin
          want = pairs_due.pop_front();
          check_field("mark_us", want.mark, m_tdata[15:0]);
          check_field("gap_us", want.gap, m_tdata[31:16]);
          check_field("mark_only", want.mark_only, m_tuser);
          check_field("last", want.last, m_tlast);
          check_field("frame_duration_us", want.total, m_tdata[54:32]);
        end
      end
      m_tready <= ($urandom_range(99) >= sink_stall);
    end
  end

  // watchdog on beats of any kind
  always @(posedge clk) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= STALL_LIMIT) begin
      $display("ir_pulse_distance_frame_encoder regression: fail");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin : stimulus
    int ph;
    int n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register set, no idling: extremes of the command fields
    set_pressure(0, 0);
    queue_cmd(KIND_STANDARD, 32'h0000_0000, 6'd0);   // empty command, header and trailer
    queue_cmd(KIND_REPEAT, 32'hFFFF_FFFF, 6'd0);     // trailer alone
    queue_cmd(KIND_STANDARD, 32'h0000_0001, 6'd1);
    queue_cmd(KIND_REPEAT, 32'hFFFF_FFFE, 6'd1);
    queue_cmd(KIND_STANDARD, 32'hFFFF_FFFF, 6'd32);
    queue_cmd(KIND_REPEAT, 32'hAAAA_AAAA, 6'd32);
    queue_cmd(KIND_STANDARD, 32'h8000_0000, 6'd32);
    queue_cmd(KIND_STANDARD, 32'h5555_5555, 6'd33);  // count over the limit
    queue_cmd(KIND_REPEAT, 32'hFFFF_FFFF, 6'd63);
    queue_cmd(KIND_STANDARD, 32'h0000_00A5, 6'd8);
    queue_cmd(KIND_STANDARD, 32'h0000_1234, 6'd16);
    queue_cmd(KIND_REPEAT, 32'h7FFF_FFFF, 6'd31);
    drain();

    // every register at its top, prefix count over the limit: longest, largest frame
    write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_pressure(54, 0);
    queue_cmd(KIND_STANDARD, 32'hFFFF_FFFF, 6'd32);
    queue_cmd(KIND_REPEAT, 32'h0000_0000, 6'd63);
    queue_cmd(KIND_STANDARD, 32'h0000_0000, 6'd0);
    for (n = 0; n < 40; n++) cmd_backlog.push_back(random_cmd());
    drain();

    // every register at zero
    write_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    set_pressure(0, 54);
    for (n = 0; n < 40; n++) cmd_backlog.push_back(random_cmd());
    drain();

    // full prefix with a mixed pattern, distinct one and zero timings
    write_timing(16'd9000, 16'd4500, 16'd560, 16'd1690, 16'd560, 16'd560, 16'hA5C3, 16'd16);
    set_pressure(11, 11);
    queue_cmd(KIND_STANDARD, 32'hFFFF_FFFF, 6'd32);
    queue_cmd(KIND_REPEAT, 32'h0000_0000, 6'd32);
    for (n = 0; n < 40; n++) cmd_backlog.push_back(random_cmd());
    drain();

    // random register sets, upper bits of the prefix count write also random
    for (ph = 0; ph < 4; ph++) begin
      write_timing(DUR_W'($urandom_range(16'hFFFF)), DUR_W'($urandom_range(16'hFFFF)),
                   DUR_W'($urandom_range(16'hFFFF)), DUR_W'($urandom_range(16'hFFFF)),
                   DUR_W'($urandom_range(16'hFFFF)), DUR_W'($urandom_range(16'hFFFF)),
                   DUR_W'($urandom_range(16'hFFFF)),
                   {11'($urandom_range(11'h7FF)), 5'($urandom_range(31))});
      case (ph)
        0:       set_pressure(0, 0);
        1:       set_pressure(54, 0);
        2:       set_pressure(0, 54);
        default: set_pressure(11, 11);
      endcase
      for (n = 0; n < 45; n++) cmd_backlog.push_back(random_cmd());
      drain();
    end

    // tail: give a stray beat time to show up
    repeat (20) @(posedge clk);
    if (pairs_due.size() != 0) begin
      mismatches++;
      $display("%0t: beats left over, expected 0, actual %0d", $time, pairs_due.size());
    end
    if (mismatches == 0)
      $display("ir_pulse_distance_frame_encoder regression: pass");
    else
      $display("ir_pulse_distance_frame_encoder regression: fail");
    $finish;
  end

endmodule
